[src/pec_pkg.sv]
// Shared constants, register codes and the result item type of the event capture unit.
`default_nettype none

package pec_pkg;

  // Sizing of the channel set and the stores
  localparam int NumPixels = 16;
  localparam int MaxEvent  = 4096;
  localparam int MaxPre    = 1024;

  // Field widths
  localparam int PixW    = 4;
  localparam int SampleW = 16;
  localparam int TickW   = 32;
  localparam int PosW    = 12;
  localparam int SizeW   = 13;
  localparam int PreW    = 10;

  // Derived store geometry
  localparam int PixIdxW  = $clog2(NumPixels);
  localparam int PtrW     = $clog2(MaxPre);
  localparam int MemDepth = NumPixels * MaxPre;
  localparam int MemAddrW = $clog2(MemDepth);
  localparam int ClrW     = MemAddrW + 1;

  // Result queue between front and back
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = FifoPtrW + 1;

  // Configuration port
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam logic RegEventSize = 1'b0;
  localparam logic RegPreBuffer = 1'b1;

  localparam logic [SizeW-1:0] EventSizeReset = SizeW'(1024);
  localparam logic [PreW-1:0]  PreBufferReset = PreW'(256);

  // One recorded sample on its way to the output
  typedef struct packed {
    logic [PixW-1:0]    pixel;
    logic [SampleW-1:0] sample;
    logic [PosW-1:0]    pos;
    logic               last;
    logic [TickW-1:0]   start_tick;
  } pec_item_t;

endpackage

`default_nettype wire

[src/pretrigger_event_capture_unit.sv]
// A result goes from the stage register into a 4-entry queue, then into the output register.
// One sample per cycle while tready is high; the queue and the output register decouple stalls.
// Each sample does one delay RAM read and, if pre_buffer is nonzero, one write in the same cycle.
// Reset: a clearing pass zeroes the 16384-entry delay RAM while tready is held low;
// register writes are taken during that pass. event_size resets to 1024, pre_buffer to 256.
`default_nettype none

module pretrigger_event_capture_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [55:0]                   s_axis_tdata,  // pixel, adc_sample, sample_tick, pad
  input  wire logic [0:0]                    s_axis_tuser,  // trigger
  // Result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [63:0]                        m_axis_tdata,  // out_pixel, out_sample,
                                                            // position_in_event, event_start_tick
  output logic                               m_axis_tlast,  // last
  // Register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pec_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [pec_pkg::CfgDataW-1:0]  pwdata,
  output logic      [pec_pkg::CfgDataW-1:0]  prdata,
  output logic                               pready
);

  import pec_pkg::*;

  logic [SizeW-1:0]    event_size_q;
  logic [PreW-1:0]     pre_buffer_q;
  logic                cfg_wr;

  logic                push, pop, nonempty;
  pec_item_t           front_item, head_item;
  logic [FifoCntW-1:0] fifo_level;

  // Register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_size_q <= EventSizeReset;
      pre_buffer_q <= PreBufferReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegEventSize: event_size_q <= pwdata[SizeW-1:0];
        RegPreBuffer: pre_buffer_q <= pwdata[PreW-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[2])
      RegEventSize: prdata = CfgDataW'(event_size_q);
      RegPreBuffer: prdata = CfgDataW'(pre_buffer_q);
      default:      prdata = '0;
    endcase
  end

  pec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .pixel_i     (s_axis_tdata[3:0]),
    .sample_i    (s_axis_tdata[19:4]),
    .tick_i      (s_axis_tdata[51:20]),
    .trigger_i   (s_axis_tuser[0]),
    .event_size_i(event_size_q),
    .pre_buffer_i(pre_buffer_q),
    .fifo_level_i(fifo_level),
    .push_o      (push),
    .item_o      (front_item)
  );

  pec_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .item_i    (front_item),
    .pop_i     (pop),
    .nonempty_o(nonempty),
    .item_o    (head_item),
    .level_o   (fifo_level)
  );

  pec_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .nonempty_i(nonempty),
    .item_i    (head_item),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

[src/pec_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module pec_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read returns the old contents when the same address is written
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/pec_front.sv]
// Front end: accepts samples, runs the per-pixel delay lines and event state, issues results.
`default_nettype none

module pec_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_valid_i,
  output logic                               s_ready_o,
  input  wire logic [pec_pkg::PixW-1:0]      pixel_i,
  input  wire logic [pec_pkg::SampleW-1:0]   sample_i,
  input  wire logic [pec_pkg::TickW-1:0]     tick_i,
  input  wire logic                          trigger_i,
  input  wire logic [pec_pkg::SizeW-1:0]     event_size_i,
  input  wire logic [pec_pkg::PreW-1:0]      pre_buffer_i,
  input  wire logic [pec_pkg::FifoCntW-1:0]  fifo_level_i,
  output logic                               push_o,
  output pec_pkg::pec_item_t                 item_o
);

  import pec_pkg::*;

  // Per-pixel state
  logic [PtrW-1:0]  ptr_q [NumPixels];
  logic             rec_q [NumPixels];
  logic [PosW-1:0]  pos_q [NumPixels];
  logic [TickW-1:0] st_q  [NumPixels];

  logic [ClrW-1:0]  clr_cnt_q, clr_cnt_d;
  logic             clr_busy;

  logic             pix_ok, take;
  logic [PixIdxW-1:0] pix_idx;
  logic [SizeW-1:0] size_used;
  logic             pre_zero;
  logic [PtrW-1:0]  ptr_rd, ptr_d;
  logic [PtrW:0]    ptr_inc;
  logic             start_ev, rec_now, fin, rec_d;
  logic [PosW-1:0]  pos_cur, pos_d;
  logic [TickW-1:0] st_cur;

  logic             ram_we;
  logic [MemAddrW-1:0] ram_waddr, ram_raddr;
  logic [SampleW-1:0]  ram_wdata, ram_rdata;

  logic             s1_valid_q, s1_valid_d;
  logic             s1_bypass_q;
  pec_item_t        s1_item_q, s1_item_d;

  // Sweep the delay store to zero after reset
  assign clr_busy  = (clr_cnt_q != ClrW'(MemDepth));
  assign clr_cnt_d = clr_cnt_q + ClrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clr_busy) begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Hold off input while clearing or when the queue could overflow
  assign s_ready_o = !clr_busy &&
    ((fifo_level_i + FifoCntW'(s1_valid_q)) < FifoCntW'(FifoDepth));

  assign pix_ok  = (9'(pixel_i) < 9'(NumPixels));
  assign take    = s_valid_i && s_ready_o && pix_ok;
  assign pix_idx = pixel_i[PixIdxW-1:0];

  // Clamp event size to its legal range
  always_comb begin
    if (event_size_i == '0) begin
      size_used = SizeW'(1);
    end else if (event_size_i > SizeW'(MaxEvent)) begin
      size_used = SizeW'(MaxEvent);
    end else begin
      size_used = event_size_i;
    end
  end

  // Delay line pointer: restart when at or beyond the length in use, wrap after advancing
  assign pre_zero = (pre_buffer_i == '0);
  assign ptr_rd   = (ptr_q[pix_idx] >= PtrW'(pre_buffer_i)) ? '0 : ptr_q[pix_idx];
  assign ptr_inc  = {1'b0, ptr_rd} + (PtrW+1)'(1);
  assign ptr_d    = (ptr_inc >= (PtrW+1)'(pre_buffer_i)) ? '0 : ptr_inc[PtrW-1:0];

  // Event state: start on trigger of an idle pixel, end after size samples
  assign start_ev = trigger_i && !rec_q[pix_idx];
  assign rec_now  = trigger_i || rec_q[pix_idx];
  assign pos_cur  = start_ev ? '0 : pos_q[pix_idx];
  assign st_cur   = start_ev ? (tick_i - TickW'(pre_buffer_i)) : st_q[pix_idx];
  assign fin      = ((SizeW'(pos_cur) + SizeW'(1)) >= size_used);

  always_comb begin
    rec_d = rec_q[pix_idx];
    pos_d = pos_q[pix_idx];
    if (rec_now) begin
      if (fin) begin
        rec_d = 1'b0;
        pos_d = '0;
      end else begin
        rec_d = 1'b1;
        pos_d = pos_cur + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPixels; i++) begin
        ptr_q[i] <= '0;
        rec_q[i] <= 1'b0;
        pos_q[i] <= '0;
      end
    end else if (take) begin
      if (!pre_zero) begin
        ptr_q[pix_idx] <= ptr_d;
      end
      rec_q[pix_idx] <= rec_d;
      pos_q[pix_idx] <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && start_ev) begin
      st_q[pix_idx] <= st_cur;
    end
  end

  // Delay store access: read the old sample and write the new one at the same slot
  assign ram_raddr = {pix_idx, ptr_rd};
  assign ram_we    = clr_busy || (take && !pre_zero);
  assign ram_waddr = clr_busy ? clr_cnt_q[MemAddrW-1:0] : ram_raddr;
  assign ram_wdata = clr_busy ? '0 : sample_i;

  pec_ram #(
    .Width(SampleW),
    .Depth(MemDepth)
  ) u_delay_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Stage register alongside the RAM read
  assign s1_valid_d = take && rec_now;

  always_comb begin
    s1_item_d.pixel      = pixel_i;
    s1_item_d.sample     = sample_i;
    s1_item_d.pos        = pos_cur;
    s1_item_d.last       = fin;
    s1_item_d.start_tick = st_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_d) begin
      s1_item_q   <= s1_item_d;
      s1_bypass_q <= pre_zero;
    end
  end

  // Pick the delayed sample: the store, or the current one when the line is bypassed
  always_comb begin
    item_o = s1_item_q;
    if (!s1_bypass_q) begin
      item_o.sample = ram_rdata;
    end
  end

  assign push_o = s1_valid_q;

endmodule

`default_nettype wire

[src/pec_fifo.sv]
// Short result queue between the front end and the output stage.
`default_nettype none

module pec_fifo (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire pec_pkg::pec_item_t           item_i,
  input  wire logic                         pop_i,
  output logic                              nonempty_o,
  output pec_pkg::pec_item_t                item_o,
  output logic [pec_pkg::FifoCntW-1:0]      level_o
);

  import pec_pkg::*;

  pec_item_t           mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q, cnt_d;

  // Track fill level
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + FifoCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign nonempty_o = (cnt_q != '0);
  assign item_o     = mem_q[rd_ptr_q];
  assign level_o    = cnt_q;

endmodule

`default_nettype wire

[src/pec_back.sv]
// Back end: output register that drains the queue into the result stream.
`default_nettype none

module pec_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                nonempty_i,
  input  wire pec_pkg::pec_item_t  item_i,
  output logic                     pop_o,
  output logic                     m_valid_o,
  input  wire logic                m_ready_i,
  output logic [63:0]              m_data_o,
  output logic                     m_last_o
);

  import pec_pkg::*;

  logic      m_valid_q;
  pec_item_t out_q;

  // Load when the register is empty or its transfer completes
  assign pop_o = nonempty_i && (!m_valid_q || m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (pop_o) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= item_i;
    end
  end

  // Pack pixel, sample, position and start tick from the lowest bit up
  assign m_valid_o = m_valid_q;
  assign m_data_o  = {out_q.start_tick, out_q.pos, out_q.sample, out_q.pixel};
  assign m_last_o  = out_q.last;

endmodule

`default_nettype wire

[sim/tb_pretrigger_event_capture_unit.sv]
// Self-checking testbench for the pretrigger event capture unit.
`timescale 1ns / 1ps

module tb_pretrigger_event_capture_unit;
  import pec_pkg::*;

  localparam int WatchdogLimit = 50000;
  localparam int SqueezeLen    = 300;
  localparam int SettleCycles  = 10;

  typedef enum int {IDLE_OFF, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_e;

  // One ADC sample as offered on the input stream
  typedef struct packed {
    logic [PixW-1:0]    pixel;
    logic [SampleW-1:0] adc;
    logic [TickW-1:0]   tick;
    logic               trig;
  } adc_word_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [55:0]         s_axis_tdata  = '0;  // pixel, adc_sample, sample_tick, pad
  logic [0:0]          s_axis_tuser  = '0;  // trigger
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [63:0]         m_axis_tdata;        // out_pixel, out_sample, position_in_event,
                                            // event_start_tick
  logic                m_axis_tlast;        // last
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [CfgAddrW-1:0] paddr         = '0;
  logic [CfgDataW-1:0] pwdata        = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // Stimulus and expectation stores
  adc_word_t sample_q[$];
  pec_item_t capture_q[$];
  adc_word_t drv_word;
  int        items_queued = 0;
  int        items_taken  = 0;
  int        err_count    = 0;
  int        idle_cycles  = 0;
  bit        in_taken     = 1'b0;
  idle_e     idle_mode    = IDLE_OFF;
  bit        squeeze_on   = 1'b0;
  int        squeeze_cnt  = 0;
  logic [TickW-1:0] tick_run = '0;

  // Predictor copy of the registers and per-pixel state
  logic [SizeW-1:0]   size_reg = EventSizeReset;
  logic [PreW-1:0]    pre_reg  = PreBufferReset;
  bit [SampleW-1:0]   line_mem [MemDepth];
  bit [PtrW-1:0]      line_ptr [NumPixels];
  bit                 busy     [NumPixels];
  bit [PosW-1:0]      pos_cnt  [NumPixels];
  bit [TickW-1:0]     ev_start [NumPixels];

  pretrigger_event_capture_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  // Draw one idle decision for the sender or the receiver side
  function automatic bit idle_draw(input bit sender);
    case (idle_mode)
      IDLE_SENDER:   return sender && ($urandom_range(0, 99) < 62);
      IDLE_RECEIVER: return !sender && ($urandom_range(0, 99) < 62);
      IDLE_BOTH:     return $urandom_range(0, 99) < 16;
      default:       return 1'b0;
    endcase
  endfunction

  // Advance the delay line of one pixel and queue the recorded sample, if any
  function automatic void capture_predict(input logic [PixW-1:0] pix,
                                          input logic [SampleW-1:0] adc,
                                          input logic [TickW-1:0] tick,
                                          input logic trig);
    int unsigned depth, span, ptr, idx, pos;
    logic [SampleW-1:0] delayed;
    pec_item_t rec;
    depth = (32'(pre_reg) > 32'(MaxPre)) ? 32'(MaxPre) : 32'(pre_reg);
    span  = (size_reg == '0) ? 32'd1 :
            ((32'(size_reg) > 32'(MaxEvent)) ? 32'(MaxEvent) : 32'(size_reg));
    if (depth == 0) begin
      delayed = adc;
    end else begin
      ptr = 32'(line_ptr[pix]);
      if (ptr >= depth) ptr = 0;
      idx = 32'(pix) * 32'(MaxPre) + ptr;
      delayed = line_mem[idx];
      line_mem[idx] = adc;
      ptr++;
      if (ptr >= depth) ptr = 0;
      line_ptr[pix] = PtrW'(ptr);
    end
    if (trig && !busy[pix]) begin
      busy[pix]     = 1'b1;
      pos_cnt[pix]  = '0;
      ev_start[pix] = tick - TickW'(depth);
    end
    if (!busy[pix]) return;
    pos = 32'(pos_cnt[pix]);
    rec.pixel      = pix;
    rec.sample     = delayed;
    rec.pos        = PosW'(pos);
    rec.last       = (pos + 1 >= span);
    rec.start_tick = ev_start[pix];
    if (rec.last) begin
      busy[pix]    = 1'b0;
      pos_cnt[pix] = '0;
    end else begin
      pos_cnt[pix] = PosW'(pos + 1);
    end
    capture_q.push_back(rec);
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic add_sample(input logic [PixW-1:0] pix, input logic [SampleW-1:0] adc,
                            input logic [TickW-1:0] tick, input logic trig);
    adc_word_t w;
    w.pixel = pix;
    w.adc   = adc;
    w.tick  = tick;
    w.trig  = trig;
    sample_q.push_back(w);
    items_queued++;
  endtask

  // Wait until every sample is taken and every result has come out
  task automatic settle();
    while (items_taken != items_queued || capture_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic reg_sel, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == RegEventSize) size_reg = value[SizeW-1:0];
    else pre_reg = value[PreW-1:0];
  endtask

  // Both registers, with random bits above each field
  task automatic set_regs(input logic [SizeW-1:0] size, input logic [PreW-1:0] pre);
    write_reg(RegEventSize, ($urandom() & ~32'h1FFF) | CfgDataW'(size));
    write_reg(RegPreBuffer, ($urandom() & ~32'h3FF) | CfgDataW'(pre));
  endtask

  task automatic run_phase(input logic [SizeW-1:0] size, input logic [PreW-1:0] pre,
                           input int count, input int trig_pct, input int pix_hi,
                           input idle_e mode, input bit squeeze);
    settle();
    set_regs(size, pre);
    idle_mode  = mode;
    squeeze_on = squeeze;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 15) == 0) tick_run = $urandom();
      else tick_run++;
      add_sample(PixW'($urandom_range(0, pix_hi)), SampleW'($urandom_range(0, 65535)),
                 tick_run, $urandom_range(0, 99) < trig_pct);
    end
  endtask

  // Input driver: hold the offered sample until its transfer
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_taken) begin
      if (rst_ni && sample_q.size() != 0 && !idle_draw(1'b1)) begin
        drv_word = sample_q.pop_front();
        s_axis_tdata  <= {4'b0, drv_word.tick, drv_word.adc, drv_word.pixel};
        s_axis_tuser  <= drv_word.trig;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result ready: one long hold-off when asked, random stalls otherwise
  always @(negedge clk_i) begin
    if (squeeze_on && squeeze_cnt < SqueezeLen) begin
      squeeze_cnt   <= squeeze_cnt + 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !idle_draw(1'b0);
    end
  end

  // Monitor: predict on input transfers, check output transfers
  always @(posedge clk_i) begin
    pec_item_t want;
    in_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_taken) begin
      capture_predict(s_axis_tdata[3:0], s_axis_tdata[19:4], s_axis_tdata[51:20],
                      s_axis_tuser[0]);
      items_taken++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (capture_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 0);
      end else begin
        want = capture_q.pop_front();
        if (m_axis_tdata[3:0] !== want.pixel)
          report_mismatch("out_pixel", m_axis_tdata[3:0], want.pixel);
        if (m_axis_tdata[19:4] !== want.sample)
          report_mismatch("out_sample", m_axis_tdata[19:4], want.sample);
        if (m_axis_tdata[31:20] !== want.pos)
          report_mismatch("position_in_event", m_axis_tdata[31:20], want.pos);
        if (m_axis_tlast !== want.last)
          report_mismatch("last", m_axis_tlast, want.last);
        if (m_axis_tdata[63:32] !== want.start_tick)
          report_mismatch("event_start_tick", m_axis_tdata[63:32], want.start_tick);
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: short events, tick wrap, ignored retrigger, extreme values
    set_regs(13'd3, 10'd2);
    add_sample(4'd0, 16'hFFFF, 32'h0000_0000, 1'b1);
    add_sample(4'd0, 16'h0000, 32'h0000_0001, 1'b1);
    add_sample(4'd0, 16'h1234, 32'h0000_0002, 1'b0);
    add_sample(4'd0, 16'h0005, 32'h0000_0003, 1'b0);
    add_sample(4'd15, 16'hABCD, 32'hFFFF_FFFF, 1'b1);
    add_sample(4'd15, 16'hFFFF, 32'h0000_0000, 1'b0);
    add_sample(4'd15, 16'h0000, 32'h0000_0001, 1'b0);
    add_sample(4'd0, 16'h5555, 32'h0000_0004, 1'b1);
    settle();

    // Zero size acts as one, zero pre_buffer bypasses the line
    set_regs(13'd0, 10'd0);
    add_sample(4'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    add_sample(4'd7, 16'hAAAA, 32'h0000_0000, 1'b0);
    add_sample(4'd7, 16'h0000, 32'h0000_0000, 1'b1);
    add_sample(4'd8, 16'h8001, 32'h8000_0000, 1'b1);
    settle();

    // Start a long event, then shrink size and line length mid-event
    set_regs(13'd8, 10'd5);
    add_sample(4'd3, 16'h0101, 32'h0000_0100, 1'b1);
    add_sample(4'd3, 16'h0202, 32'h0000_0101, 1'b0);
    add_sample(4'd3, 16'h0303, 32'h0000_0102, 1'b1);
    add_sample(4'd3, 16'h0404, 32'h0000_0103, 1'b0);
    settle();
    set_regs(13'd2, 10'd2);
    add_sample(4'd3, 16'h0505, 32'h0000_0104, 1'b0);
    add_sample(4'd3, 16'h0606, 32'h0000_0105, 1'b1);
    add_sample(4'd3, 16'h0707, 32'h0000_0106, 1'b0);
    add_sample(4'd3, 16'h0808, 32'h0000_0107, 1'b0);

    // Random phases over several register settings and idle patterns
    run_phase(13'd4,    10'd3,    250, 20, 15, IDLE_OFF,      1'b0);
    run_phase(13'd1,    10'd0,    150, 30, 15, IDLE_SENDER,   1'b0);
    run_phase(13'd4096, 10'd1,    200, 10, 3,  IDLE_RECEIVER, 1'b0);
    run_phase(13'd8191, 10'd1023, 200, 5,  1,  IDLE_BOTH,     1'b0);
    run_phase(13'd0,    10'd7,    150, 25, 15, IDLE_OFF,      1'b1);
    run_phase(13'd17,   10'd5,    300, 15, 2,  IDLE_SENDER,   1'b0);
    run_phase(13'd2,    10'd2,    250, 40, 15, IDLE_RECEIVER, 1'b0);
    run_phase(13'd64,   10'd12,   200, 10, 7,  IDLE_BOTH,     1'b0);
    settle();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
src/pec_pkg.sv
src/pec_ram.sv
src/pec_front.sv
src/pec_fifo.sv
src/pec_back.sv
src/pretrigger_event_capture_unit.sv
sim/tb_pretrigger_event_capture_unit.sv
